[hw/rtl/meeoc_pkg.sv]
`timescale 1ns / 1ps

package meeoc_pkg;

  localparam int POS_W = 24;
  localparam int DIFF_W = POS_W + 1;
  localparam int SUM_W = 28;
  localparam int MAG_SLOTS = 4;
  localparam int MAG_IDX_W = 2;
  localparam int NUM_MAGNETS_DEF = 4;
  localparam int EDGE_W_DEF = 3;

  localparam logic signed [POS_W-1:0] AVG_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] AVG_MIN = 24'sh800000;
  localparam logic [SUM_W-1:0] MAG_POS_LIMIT = 28'd8388607;
  localparam logic [SUM_W-1:0] MAG_NEG_LIMIT = 28'd8388608;

  // Request codes.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic                    hall_active;
    logic signed [POS_W-1:0] encoder_count;
  } sample_t;

  typedef struct packed {
    logic signed [POS_W-1:0] avg_offset;
    logic                    calibrated;
    logic                    edge_seen;
    logic [MAG_IDX_W-1:0]    magnet_index;
  } result_t;

endpackage

[hw/rtl/meeoc_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The quotient shifts in
// where the dividend shifts out, so one register holds both.
module meeoc_div #(
  parameter int DW = meeoc_pkg::SUM_W,
  parameter int VW = meeoc_pkg::EDGE_W_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [VW-1:0]    rem;
  logic [VW-1:0]    dvs;
  logic [DW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [VW:0]      shifted;
  logic [VW:0]      trial;
  logic             fits;

  assign shifted = {rem, quo[DW-1]};
  assign trial = shifted - {1'b0, dvs};
  assign fits = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[VW-1:0] : shifted[VW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

[hw/rtl/magnet_edge_encoder_offset_calibrator.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// sample    in         sample_valid/sample_ready  sample (req_type, hall, count)
// result    out        result_valid/result_ready  result (avg, calibrated, edge, index)
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data (magnet positions)
//
// After a sample transfers, the block computes the offset, updates the state, starts the
// divider, runs 28 restoring divider steps, sees it finish and loads the output register.
// It takes the next sample only after that load. If the previous result still waits
// at that point, the block holds and sample_ready stays low until it transfers.
// Reset (synchronous) clears the calibration state and the magnet positions.
module magnet_edge_encoder_offset_calibrator #(
  parameter int NUM_MAGNETS = meeoc_pkg::NUM_MAGNETS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  meeoc_pkg::sample_t                  sample,
  output logic                                result_valid,
  input  logic                                result_ready,
  output meeoc_pkg::result_t                  result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [meeoc_pkg::MAG_IDX_W-1:0]     cfg_index,
  input  logic signed [meeoc_pkg::POS_W-1:0]  cfg_data
);

  localparam int POS_W = meeoc_pkg::POS_W;
  localparam int DIFF_W = meeoc_pkg::DIFF_W;
  localparam int SUM_W = meeoc_pkg::SUM_W;
  localparam int IDX_W = $clog2(NUM_MAGNETS);
  localparam int EC_W = $clog2(2 * NUM_MAGNETS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIFF = 6'b000010,
    ST_ACC  = 6'b000100,
    ST_ABS  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state;

  logic signed [POS_W-1:0] magnet_pos [meeoc_pkg::MAG_SLOTS];
  meeoc_pkg::sample_t      item;
  logic signed [DIFF_W-1:0] diff;
  logic                    prev_hall;
  logic [IDX_W-1:0]        mag_index;
  logic                    going_down;
  logic signed [SUM_W-1:0] offset_sum;
  logic [EC_W-1:0]         edge_count;
  logic                    edge_seen;
  logic                    sum_neg;

  logic                    calibrated;
  logic                    at_top;
  logic [SUM_W-1:0]        sum_mag;
  logic                    div_start;
  logic                    div_done;
  logic [SUM_W-1:0]        quotient;
  logic signed [POS_W-1:0] avg;
  logic                    out_free;

  assign calibrated = edge_count == EC_W'(2 * NUM_MAGNETS - 1);
  assign at_top = mag_index == IDX_W'(NUM_MAGNETS - 1);
  assign sum_mag = offset_sum[SUM_W-1] ? SUM_W'(-offset_sum) : SUM_W'(offset_sum);
  assign div_start = state == ST_ABS;
  assign sample_ready = state == ST_IDLE;
  assign cfg_ready = 1'b1;
  assign out_free = !result_valid || result_ready;

  meeoc_div #(
    .DW(SUM_W),
    .VW(EC_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum_mag),
    .divisor (edge_count),
    .done    (div_done),
    .quotient(quotient)
  );

  // Give zero before the first edge; otherwise apply the sign and clamp to the 24-bit range.
  always_comb begin
    if (edge_count == '0) begin
      avg = '0;
    end else if (sum_neg) begin
      avg = (quotient > meeoc_pkg::MAG_NEG_LIMIT) ? meeoc_pkg::AVG_MIN
                                                  : POS_W'(-quotient);
    end else begin
      avg = (quotient > meeoc_pkg::MAG_POS_LIMIT) ? meeoc_pkg::AVG_MAX
                                                  : POS_W'(quotient);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < meeoc_pkg::MAG_SLOTS; i++) begin
        magnet_pos[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      magnet_pos[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      prev_hall <= 1'b0;
      mag_index <= IDX_W'(1);
      going_down <= 1'b0;
      offset_sum <= '0;
      edge_count <= '0;
      edge_seen <= 1'b0;
      sum_neg <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          edge_seen <= item.req_type != meeoc_pkg::REQ_RESTART && !calibrated
                       && item.hall_active != prev_hall;
          if (item.req_type == meeoc_pkg::REQ_RESTART) begin
            prev_hall <= 1'b0;
            mag_index <= IDX_W'(1);
            going_down <= 1'b0;
            offset_sum <= '0;
            edge_count <= '0;
          end else if (!calibrated) begin
            if (item.hall_active != prev_hall) begin
              offset_sum <= offset_sum + SUM_W'(diff);
              edge_count <= edge_count + 1'b1;
              if (!going_down && !at_top) begin
                mag_index <= mag_index + 1'b1;
              end else if (going_down && mag_index != '0) begin
                mag_index <= mag_index - 1'b1;
              end
              if (at_top) begin
                going_down <= 1'b1;
              end
            end
            prev_hall <= item.hall_active;
          end
          state <= ST_ABS;
        end
        ST_ABS: begin
          sum_neg <= offset_sum[SUM_W-1];
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      item <= sample;
    end
    if (state == ST_DIFF) begin
      diff <= DIFF_W'(item.encoder_count)
            - DIFF_W'(magnet_pos[meeoc_pkg::MAG_IDX_W'(mag_index)]);
    end
    if (state == ST_OUT && out_free) begin
      result.avg_offset <= avg;
      result.calibrated <= calibrated;
      result.edge_seen <= edge_seen;
      result.magnet_index <= meeoc_pkg::MAG_IDX_W'(mag_index);
    end
  end

endmodule

[verif/offset_calibration_checker.sv]
`timescale 1ns / 1ps

module offset_calibration_checker #(
  parameter int NUM_MAGNETS = meeoc_pkg::NUM_MAGNETS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  input  logic                               sample_ready,
  input  meeoc_pkg::sample_t                 sample,
  input  logic                               result_valid,
  input  logic                               result_ready,
  input  meeoc_pkg::result_t                 result,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [meeoc_pkg::MAG_IDX_W-1:0]    cfg_index,
  input  logic signed [meeoc_pkg::POS_W-1:0] cfg_data,
  output int                                 mismatch_count,
  output int                                 pending_results
);

  localparam int POS_W = meeoc_pkg::POS_W;
  localparam int SUM_W = meeoc_pkg::SUM_W;
  localparam int MAG_SLOTS = meeoc_pkg::MAG_SLOTS;
  localparam int MAG_IDX_W = meeoc_pkg::MAG_IDX_W;
  localparam logic [3:0] CAL_EDGES = 4'(2 * NUM_MAGNETS - 1);
  localparam logic [2:0] TOP_MAGNET = 3'(NUM_MAGNETS - 1);

  logic signed [POS_W-1:0] mag_pos [MAG_SLOTS];
  logic                    last_hall;
  logic [2:0]              mag_idx;
  logic                    heading_down;
  logic signed [SUM_W-1:0] offset_acc;
  logic [3:0]              edge_cnt;
  meeoc_pkg::result_t      expected_q [$];
  int                      failures = 0;

  function automatic void clear_calibration();
    last_hall = 1'b0;
    mag_idx = 3'd1;
    heading_down = 1'b0;
    offset_acc = '0;
    edge_cnt = '0;
  endfunction

  // Applies one sample to the calibration state and returns the result it should produce.
  function automatic meeoc_pkg::result_t advance_calibration(meeoc_pkg::sample_t s);
    meeoc_pkg::result_t r;
    logic [MAG_IDX_W-1:0] slot;
    logic at_top;
    longint diff;
    longint avg;
    r = '0;
    avg = 0;
    if (s.req_type == meeoc_pkg::REQ_RESTART) begin
      clear_calibration();
    end else if (edge_cnt != CAL_EDGES) begin
      if (s.hall_active != last_hall) begin
        slot = mag_idx[MAG_IDX_W-1:0];
        at_top = (mag_idx == TOP_MAGNET);
        diff = longint'(s.encoder_count) - longint'(mag_pos[slot]);
        offset_acc = offset_acc + diff[SUM_W-1:0];
        edge_cnt = edge_cnt + 4'd1;
        if (!heading_down && !at_top) begin
          mag_idx = mag_idx + 3'd1;
        end else if (heading_down && mag_idx != 3'd0) begin
          mag_idx = mag_idx - 3'd1;
        end
        if (at_top) begin
          heading_down = 1'b1;
        end
        r.edge_seen = 1'b1;
      end
      last_hall = s.hall_active;
    end
    if (edge_cnt != 4'd0) begin
      avg = longint'(offset_acc) / longint'(edge_cnt);
      if (avg > longint'(meeoc_pkg::AVG_MAX)) begin
        avg = longint'(meeoc_pkg::AVG_MAX);
      end
      if (avg < longint'(meeoc_pkg::AVG_MIN)) begin
        avg = longint'(meeoc_pkg::AVG_MIN);
      end
    end
    r.avg_offset = avg[POS_W-1:0];
    r.calibrated = (edge_cnt == CAL_EDGES);
    r.magnet_index = mag_idx[MAG_IDX_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    meeoc_pkg::result_t want;
    if (rst) begin
      for (int i = 0; i < MAG_SLOTS; i++) begin
        mag_pos[i] = '0;
      end
      clear_calibration();
      expected_q.delete();
    end else begin
      // The result side is checked first: a result leaving at this edge always
      // belongs to a sample that transferred earlier.
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: result with nothing expected: avg=%0d cal=%0b edge=%0b idx=%0d",
                     $realtime, result.avg_offset, result.calibrated, result.edge_seen,
                     result.magnet_index);
          end
        end else begin
          want = expected_q.pop_front();
          if (result.avg_offset !== want.avg_offset || result.calibrated !== want.calibrated ||
              result.edge_seen !== want.edge_seen ||
              result.magnet_index !== want.magnet_index) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: result mismatch: expected avg=%0d cal=%0b edge=%0b idx=%0d",
                       $realtime, want.avg_offset, want.calibrated, want.edge_seen,
                       want.magnet_index);
              $display("%0t:                  actual   avg=%0d cal=%0b edge=%0b idx=%0d",
                       $realtime, result.avg_offset, result.calibrated, result.edge_seen,
                       result.magnet_index);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        mag_pos[cfg_index] = cfg_data;
      end
      if (sample_valid && sample_ready) begin
        expected_q.push_back(advance_calibration(sample));
      end
    end
    mismatch_count <= failures;
    pending_results <= expected_q.size();
  end

endmodule

[verif/magnet_edge_encoder_offset_calibrator_tb.sv]
`timescale 1ns / 1ps

module magnet_edge_encoder_offset_calibrator_tb;

  localparam int POS_W = meeoc_pkg::POS_W;
  localparam int MAG_SLOTS = meeoc_pkg::MAG_SLOTS;
  localparam int MAG_IDX_W = meeoc_pkg::MAG_IDX_W;
  localparam int NUM_MAGNETS = meeoc_pkg::NUM_MAGNETS_DEF;
  localparam int CAL_EDGES = 2 * NUM_MAGNETS - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int CHUNK_ITEMS = 128;
  localparam logic signed [POS_W-1:0] COUNT_MIN = {1'b1, {(POS_W - 1){1'b0}}};
  localparam logic signed [POS_W-1:0] COUNT_MAX = {1'b0, {(POS_W - 1){1'b1}}};

  typedef enum int {
    POS_ALL_MIN,
    POS_ALL_MAX,
    POS_WIDE,
    POS_CLOSE
  } pos_style_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    sample_valid = 1'b0;
  logic                    sample_ready;
  meeoc_pkg::sample_t      sample = '0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  meeoc_pkg::result_t      result;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [MAG_IDX_W-1:0]    cfg_index = '0;
  logic signed [POS_W-1:0] cfg_data = '0;

  int mismatch_count;
  int pending_results;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;

  // Stimulus-side view of the sequence, used to shape well-formed edge runs.
  logic gen_hall = 1'b0;
  int   gen_edges = 0;
  int   counted = 0;
  logic signed [POS_W-1:0] next_pos [MAG_SLOTS];

  magnet_edge_encoder_offset_calibrator #(
    .NUM_MAGNETS(NUM_MAGNETS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  offset_calibration_checker #(
    .NUM_MAGNETS(NUM_MAGNETS)
  ) checker_inst (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_count(mismatch_count),
    .pending_results(pending_results)
  );

  always #5 clk = ~clk;

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Valid is left high after a transfer; the next call either keeps it high
  // with a new payload or drops it for an idle gap.
  task automatic send_sample(input logic req, input logic hall,
                             input logic signed [POS_W-1:0] count);
    meeoc_pkg::sample_t s;
    s.req_type = req;
    s.hall_active = hall;
    s.encoder_count = count;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    counted++;
    if (req == meeoc_pkg::REQ_RESTART) begin
      gen_hall = 1'b0;
      gen_edges = 0;
    end else if (gen_edges < CAL_EDGES) begin
      if (hall != gen_hall) begin
        gen_edges++;
      end
      gen_hall = hall;
    end
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic write_positions();
    for (int i = 0; i < MAG_SLOTS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= MAG_IDX_W'(i);
      cfg_data <= next_pos[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic load_positions(input pos_style_t style);
    for (int i = 0; i < MAG_SLOTS; i++) begin
      case (style)
        POS_ALL_MIN: next_pos[i] = COUNT_MIN;
        POS_ALL_MAX: next_pos[i] = COUNT_MAX;
        POS_WIDE:    next_pos[i] = POS_W'($urandom);
        default:     next_pos[i] = POS_W'(i * 2000 - 3000) + POS_W'($urandom_range(0, 50));
      endcase
    end
    write_positions();
  endtask

  // Counts are mostly close to a magnet position, with some full-range and extreme values.
  function automatic logic signed [POS_W-1:0] pick_count();
    int dice;
    dice = $urandom_range(0, 99);
    if (dice < 10) begin
      case ($urandom_range(0, 3))
        0: return COUNT_MIN;
        1: return COUNT_MAX;
        2: return '0;
        default: return '1;
      endcase
    end else if (dice < 45) begin
      return POS_W'($urandom);
    end
    return next_pos[$urandom_range(0, MAG_SLOTS - 1)] + POS_W'($urandom_range(0, 400)) -
           POS_W'(200);
  endfunction

  task automatic run_random(input int quota);
    int stop_at;
    int dice;
    stop_at = counted + quota;
    while (counted < stop_at) begin
      dice = $urandom_range(0, 99);
      if (dice < 3 || (gen_edges >= CAL_EDGES && dice < 40)) begin
        send_sample(meeoc_pkg::REQ_RESTART, 1'($urandom), POS_W'($urandom));
      end else if (gen_edges < CAL_EDGES && dice < 80) begin
        send_sample(meeoc_pkg::REQ_SAMPLE, ~gen_hall, pick_count());
      end else begin
        send_sample(meeoc_pkg::REQ_SAMPLE, 1'($urandom), pick_count());
      end
    end
  endtask

  initial begin
    #(5_000_000);
    $display("magnet_edge_encoder_offset_calibrator_tb failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extreme positions: the first edge saturates the average low, and the
    // final edge at the bottom magnet adds the largest possible offset.
    next_pos[0] = COUNT_MIN;
    next_pos[1] = COUNT_MAX;
    next_pos[2] = 24'sd1000;
    next_pos[3] = -24'sd1;
    write_positions();
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b0, '0);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b1, COUNT_MIN);
    send_sample(meeoc_pkg::REQ_RESTART, 1'b1, COUNT_MAX);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b1, COUNT_MAX);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b1, 24'sd5);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b0, -24'sd1);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b1, 24'sd1003);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b0, '0);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b1, 24'sd999);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b0, COUNT_MAX);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b1, COUNT_MAX);
    // Calibrated now, so these change nothing.
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b0, 24'sd7);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b0, COUNT_MIN);
    send_sample(meeoc_pkg::REQ_RESTART, 1'b0, '0);
    drain();

    // Positions that make the first average saturate high.
    next_pos[0] = COUNT_MAX;
    next_pos[1] = COUNT_MIN;
    next_pos[2] = COUNT_MIN;
    next_pos[3] = COUNT_MAX;
    write_positions();
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b1, COUNT_MAX);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b1, COUNT_MIN);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b0, COUNT_MIN);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b1, -24'sd1);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b0, COUNT_MIN);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b1, '0);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b0, COUNT_MAX);
    send_sample(meeoc_pkg::REQ_SAMPLE, 1'b1, COUNT_MIN);
    send_sample(meeoc_pkg::REQ_RESTART, 1'b1, '1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 49;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 49;
        end
        default: begin
          send_idle_pct = 6;
          recv_stall_pct = 6;
        end
      endcase
      for (int c = 0; c < 2; c++) begin
        drain();
        load_positions(pos_style_t'((p * 2 + c) % 4));
        // The result side holds off while samples keep coming, so the block backs up.
        if (p == 0 && c == 1) begin
          hold_req = 1'b1;
        end
        run_random(CHUNK_ITEMS);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("magnet_edge_encoder_offset_calibrator_tb passed");
    end else begin
      $display("magnet_edge_encoder_offset_calibrator_tb failed");
    end
    $finish;
  end

endmodule
